// File: rtl/core/itirs_pkg.sv
// ----------------------------------------------------------------------------
// itirs_pkg
// Shared types and constants of the indexed key table: opcodes, status
// codes, control state, cell control and result records.
// ----------------------------------------------------------------------------
package itirs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int IDX_W       = 7;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 2);
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int CMP_W       = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    localparam int IN_DATA_W   = ((IDX_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + CNT_W + 2 + CNT_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // find priority tree
    localparam int GRP         = 8;
    localparam int GRP_W       = 3;
    localparam int NGRP        = (TABLE_DEPTH + GRP - 1) / GRP;
    localparam int NG_W        = (NGRP > 1) ? $clog2(NGRP) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_FWAIT,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [CNT_W-1:0] idx;
    } t_cell_ctl;

    typedef struct packed {
        logic          vld;
        logic          found;
        logic [AW-1:0] pos;
    } t_prio_res;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_status          status;
        logic [CNT_W-1:0] position;
        logic             found;
    } t_result;

endpackage

// File: rtl/core/itirs_cell.sv
// ----------------------------------------------------------------------------
// itirs_cell
// One table slot: holds a key, takes its neighbor's key on a shift, loads
// the new key on insert and flags equality with the search key.
// ----------------------------------------------------------------------------
module itirs_cell
    import itirs_pkg::*;
(
    input  logic             i_clk,
    input  logic [AW-1:0]    i_pos,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [KEY_W-1:0] i_prev,
    input  logic [KEY_W-1:0] i_next,
    input  logic [KEY_W-1:0] i_skey,
    output logic [KEY_W-1:0] o_key,
    output logic             o_eq
);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic [CNT_W-1:0] w_pos;

    assign w_pos = CNT_W'(i_pos);

    always_comb begin
        n_key = r_key;
        priority if (i_ctl.ins && (w_pos > i_ctl.idx)) begin
            n_key = i_prev;
        end else if (i_ctl.ins && (w_pos == i_ctl.idx)) begin
            n_key = i_key;
        end else if (i_ctl.rem && (w_pos >= i_ctl.idx)) begin
            n_key = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_eq  = (r_key == i_skey);

endmodule

// File: rtl/core/itirs_prio.sv
// ----------------------------------------------------------------------------
// itirs_prio
// Registered first-match search over the cell hit flags: capture, per-group
// encode of eight flags, then pick the lowest group with a hit.
// ----------------------------------------------------------------------------
module itirs_prio
    import itirs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic [TABLE_DEPTH-1:0] i_vec,
    output t_prio_res              o_res
);

    logic                    r_v0;
    logic                    r_v1;
    logic                    r_v2;
    logic [NGRP*GRP-1:0]     r_vec;
    logic [NGRP-1:0]         r_gany;
    logic [GRP_W-1:0]        r_gidx [NGRP];
    logic                    r_found;
    logic [AW-1:0]           r_pos;

    logic [NGRP-1:0]         n_gany;
    logic [GRP_W-1:0]        n_gidx [NGRP];
    logic                    n_found;
    logic [AW-1:0]           n_pos;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_gany[g] = 1'b0;
            n_gidx[g] = '0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (r_vec[g*GRP+b]) begin
                    n_gany[g] = 1'b1;
                    n_gidx[g] = GRP_W'(b);
                end
            end
        end
    end

    always_comb begin
        n_found = 1'b0;
        n_pos   = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_gany[g]) begin
                n_found = 1'b1;
                n_pos   = AW'({NG_W'(g), r_gidx[g]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec   <= (NGRP*GRP)'(i_vec);
        r_gany  <= n_gany;
        r_gidx  <= n_gidx;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

    assign o_res.vld   = r_v2;
    assign o_res.found = r_found;
    assign o_res.pos   = r_pos;

endmodule

// File: rtl/core/indexed_table_insert_remove_search_top.sv
// Insert and remove load the registered result word directly; find runs a
// cell compare, then a three-stage registered priority tree; sorted lookup
// takes one halving step of the cell read mux per cycle.
// Throughput: insert/remove one word per cycle unless the result word is
// held; find and lookup hold the input until done. Synchronous active-low reset
// clears the count, control and output valid; table cells hold no reset value.
// ----------------------------------------------------------------------------
// indexed_table_insert_remove_search_top
// Ordered key table built as a row of shifting cells, with insert, remove,
// linear first-match find and binary-search lookup.
// ----------------------------------------------------------------------------
module indexed_table_insert_remove_search_top
    import itirs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // index, key, zero pad
    input  logic [OP_W-1:0]       s_axis_tuser,  // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // found, position, status, count, zero pad
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [KEY_W-1:0]  r_skey;
    logic [KEY_W-1:0]  n_skey;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  n_lo;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  n_hi;
    logic [CNT_W-1:0]  r_mid;
    logic [CNT_W-1:0]  n_mid;
    logic              r_out_vld;
    logic              n_out_vld;
    t_result           r_out;
    t_result           n_out;

    logic                   w_accept;
    logic                   w_in_rdy;
    t_op                    w_op;
    logic [IDX_W-1:0]       w_idx;
    logic [KEY_W-1:0]       w_key;
    logic [CMP_W-1:0]       w_idx_c;
    logic [CMP_W-1:0]       w_cnt_c;
    t_cell_ctl              w_ctl;
    logic                   w_load;
    t_result                w_res;
    logic                   w_prio_go;
    t_prio_res              w_prio;
    logic                   w_look_done;
    logic [CNT_W-1:0]       w_mid;
    logic [CNT_W-1:0]       w_mid_m1;
    logic [KEY_W-1:0]       w_v;
    logic [KEY_W-1:0]       w_keys [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] w_hits;

    assign w_op     = t_op'(s_axis_tuser);
    assign w_idx    = s_axis_tdata[IDX_W-1:0];
    assign w_key    = s_axis_tdata[IDX_W+KEY_W-1:IDX_W];
    assign w_idx_c  = CMP_W'(w_idx);
    assign w_cnt_c  = CMP_W'(r_count);
    assign w_in_rdy = (r_state == ST_IDLE) && (!r_out_vld || m_axis_tready);
    assign w_accept = s_axis_tvalid && w_in_rdy;

    // cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] w_prev;
        logic [KEY_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_keys[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_next = w_keys[g];
        end else begin : g_body
            assign w_next = w_keys[g+1];
        end
        itirs_cell u_cell (
            .i_clk  (i_clk),
            .i_pos  (AW'(g)),
            .i_ctl  (w_ctl),
            .i_key  (w_key),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_skey (r_skey),
            .o_key  (w_keys[g]),
            .o_eq   (w_eq[g])
        );
        assign w_hits[g] = w_eq[g] && (CNT_W'(g) < r_count);
    end

    itirs_prio u_prio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_prio_go),
        .i_vec   (w_hits),
        .o_res   (w_prio)
    );

    // binary search step
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_mid_m1 = w_mid - CNT_W'(1);
    assign w_v      = w_keys[w_mid_m1[AW-1:0]];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_op == OP_FIND)) begin
                    n_state = ST_FIND;
                end else if (w_accept && (w_op == OP_LOOKUP)) begin
                    n_state = ST_LOOK;
                end
            end
            ST_FIND:  n_state = ST_FWAIT;
            ST_FWAIT: begin
                if (w_prio.vld) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOK: begin
                if (w_look_done) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl       = '0;
        w_load      = 1'b0;
        w_prio_go   = 1'b0;
        w_look_done = 1'b0;
        w_res       = '{count: r_count, status: STS_OK, position: '0, found: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_INSERT: begin
                            w_load = 1'b1;
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                w_res.status = STS_FULL;
                            end else begin
                                w_ctl.ins      = 1'b1;
                                w_ctl.idx      = (w_idx_c > w_cnt_c) ? r_count
                                                                     : CNT_W'(w_idx);
                                w_res.position = w_ctl.idx;
                                w_res.count    = r_count + CNT_W'(1);
                            end
                        end
                        OP_REMOVE: begin
                            w_load = 1'b1;
                            if (w_idx_c >= w_cnt_c) begin
                                w_res.status = STS_RANGE;
                            end else begin
                                w_ctl.rem      = 1'b1;
                                w_ctl.idx      = CNT_W'(w_idx);
                                w_res.position = CNT_W'(w_idx);
                                w_res.count    = r_count - CNT_W'(1);
                            end
                        end
                        OP_FIND, OP_LOOKUP: ;
                        default: ;
                    endcase
                end
            end
            ST_FIND: begin
                w_prio_go = 1'b1;
            end
            ST_FWAIT: begin
                if (w_prio.vld) begin
                    w_load      = 1'b1;
                    w_res.found = w_prio.found;
                    w_res.position = w_prio.found ? CNT_W'(w_prio.pos) : '0;
                end
            end
            ST_LOOK: begin
                if (r_lo > r_hi) begin
                    w_look_done    = 1'b1;
                    w_res.position = r_mid;
                end else if (w_v > r_skey) begin
                    if (w_mid_m1 < r_lo) begin
                        w_look_done    = 1'b1;
                        w_res.position = w_mid_m1;
                    end
                end else if (w_v == r_skey) begin
                    w_look_done    = 1'b1;
                    w_res.found    = 1'b1;
                    w_res.position = w_mid_m1;
                end
                w_load = w_look_done;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_skey    = r_skey;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_out     = r_out;
        n_out_vld = r_out_vld && !m_axis_tready;
        if (w_load) begin
            n_out     = w_res;
            n_out_vld = 1'b1;
            n_count   = w_res.count;
        end
        if (w_accept) begin
            n_skey = w_key;
            n_lo   = CNT_W'(1);
            n_hi   = r_count;
            n_mid  = '0;
        end else if ((r_state == ST_LOOK) && (r_lo <= r_hi)) begin
            n_mid = w_mid;
            if (w_v > r_skey) begin
                n_hi = w_mid_m1;
            end else begin
                n_lo = w_mid + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skey <= n_skey;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_out  <= n_out;
    end

    assign s_axis_tready = w_in_rdy;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_vld || m_axis_tready))
        else $error("result word overwritten before taken");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while a search runs");

    a_prio_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_prio.vld |-> (r_state == ST_FWAIT))
        else $error("find result outside wait state");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> $stable(r_count))
        else $error("count changed during lookup");
`endif

endmodule

// File: tb/sv/indexed_table_insert_remove_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_table_insert_remove_search_top_tb
// Self-checking bench for the indexed key table. A short directed table
// covers the empty table, extreme keys and indexes, appends, out-of-range
// removes, duplicates and unsorted lookups. Random rounds then fill the table
// to full with mostly sorted inserts, drain it with removes, mix all operations.
// Each result word is checked per field against a typed want or a shadow table.
// ----------------------------------------------------------------------------
module indexed_table_insert_remove_search_top_tb;
    import itirs_pkg::*;

    localparam int LIMIT = 400000;
    localparam int ITEMS = 1050;

    typedef struct {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        int               typed;
        t_result          want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // index, key, zero pad
    logic [OP_W-1:0]       s_axis_tuser = '0;  // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // found, position, status, count, zero pad

    logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    int               shadow_count = 0;
    t_result          pending_results [$];
    int               errors = 0;
    int               cycles = 0;
    bit               steady = 1'b0;

    indexed_table_insert_remove_search_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("indexed_table_insert_remove_search_top_tb NOT OK");
            $finish;
        end
    end

    function automatic t_result make_res(int f, int pos, t_status st, int cnt);
        t_result r;
        r.found    = f[0];
        r.position = CNT_W'(pos);
        r.status   = st;
        r.count    = CNT_W'(cnt);
        return r;
    endfunction

    // applies one operation to the shadow table and returns its result word
    function automatic t_result table_apply(t_op op, int idx, logic [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        int hit;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= TABLE_DEPTH)
                    return make_res(0, 0, STS_FULL, shadow_count);
                if (idx > shadow_count)
                    idx = shadow_count;
                for (int i = shadow_count; i > idx; i--)
                    shadow_keys[i] = shadow_keys[i-1];
                shadow_keys[idx] = key;
                shadow_count++;
                return make_res(0, idx, STS_OK, shadow_count);
            end
            OP_REMOVE: begin
                if (idx >= shadow_count)
                    return make_res(0, 0, STS_RANGE, shadow_count);
                for (int i = idx; i + 1 < shadow_count; i++)
                    shadow_keys[i] = shadow_keys[i+1];
                shadow_count--;
                return make_res(0, idx, STS_OK, shadow_count);
            end
            OP_FIND: begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == key)
                        return make_res(1, i, STS_OK, shadow_count);
                return make_res(0, 0, STS_OK, shadow_count);
            end
            default: begin
                // 1-based halving search
                lo  = 1;
                hi  = shadow_count;
                mid = 0;
                hit = 0;
                while (lo <= hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (shadow_keys[mid-1] > key) begin
                        hi = mid - 1;
                        if (hi < lo) begin
                            mid--;
                            break;
                        end
                    end else if (shadow_keys[mid-1] < key) begin
                        lo = mid + 1;
                    end else begin
                        hit = 1;
                        mid--;
                        break;
                    end
                end
                return make_res(hit, mid, STS_OK, shadow_count);
            end
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        case ($urandom_range(9))
            0: k = '0;
            1: k = '1;
            2, 3: if (shadow_count > 0) k = shadow_keys[$urandom_range(shadow_count-1)];
            4: if (shadow_count > 0)
                k = shadow_keys[$urandom_range(shadow_count-1)] + ($urandom_range(1) ? 1 : -1);
            5, 6: k = $urandom_range(15);
            default: ;
        endcase
        return k;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0d: %0s", cycles, msg);
        errors++;
    endtask

    task automatic send(t_op op, int idx, logic [KEY_W-1:0] key,
                        int typed = 0, t_result want = '0);
        t_result r;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({key, IDX_W'(idx)});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = table_apply(op, idx, key);
        pending_results.push_back((typed != 0) ? want : r);
    endtask

    always @(negedge i_clk)
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 17);

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_BITS-1:0];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found)
                    report_mismatch($sformatf("found got %0d expected %0d",
                                              got.found, want.found));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position got %0d expected %0d",
                                              got.position, want.position));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              got.status, want.status));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              got.count, want.count));
            end
        end
    end

    initial begin
        t_row             plan [22];
        int               sent;
        int               round;
        int               slot;
        logic [KEY_W-1:0] k;

        plan = '{
            '{OP_LOOKUP, 7'd0,   32'h0000_0000, 1, make_res(0, 0, STS_OK,    0)},
            '{OP_REMOVE, 7'd0,   32'h0000_0000, 1, make_res(0, 0, STS_RANGE, 0)},
            '{OP_FIND,   7'd0,   32'hFFFF_FFFF, 1, make_res(0, 0, STS_OK,    0)},
            '{OP_INSERT, 7'd127, 32'hFFFF_FFFF, 1, make_res(0, 0, STS_OK,    1)},
            '{OP_INSERT, 7'd0,   32'h0000_0000, 1, make_res(0, 0, STS_OK,    2)},
            '{OP_INSERT, 7'd1,   32'h8000_0000, 1, make_res(0, 1, STS_OK,    3)},
            '{OP_INSERT, 7'd3,   32'hFFFF_FFFF, 1, make_res(0, 3, STS_OK,    4)},
            '{OP_FIND,   7'd0,   32'hFFFF_FFFF, 1, make_res(1, 2, STS_OK,    4)},
            '{OP_LOOKUP, 7'd0,   32'hFFFF_FFFF, 0, '0},
            '{OP_LOOKUP, 7'd0,   32'h0000_0000, 0, '0},
            '{OP_LOOKUP, 7'd0,   32'h7FFF_FFFF, 0, '0},
            '{OP_LOOKUP, 7'd0,   32'hFFFF_FFFE, 0, '0},
            '{OP_REMOVE, 7'd127, 32'h0000_0000, 1, make_res(0, 0, STS_RANGE, 4)},
            '{OP_REMOVE, 7'd4,   32'h0000_0000, 1, make_res(0, 0, STS_RANGE, 4)},
            '{OP_REMOVE, 7'd3,   32'h0000_0000, 1, make_res(0, 3, STS_OK,    3)},
            '{OP_FIND,   7'd0,   32'h1234_5678, 1, make_res(0, 0, STS_OK,    3)},
            '{OP_INSERT, 7'd0,   32'h8000_0000, 1, make_res(0, 0, STS_OK,    4)},
            '{OP_LOOKUP, 7'd0,   32'h0000_0000, 0, '0},
            '{OP_FIND,   7'd0,   32'h8000_0000, 1, make_res(1, 0, STS_OK,    4)},
            '{OP_REMOVE, 7'd0,   32'h0000_0000, 1, make_res(0, 0, STS_OK,    3)},
            '{OP_INSERT, 7'd64,  32'h5A5A_5A5A, 1, make_res(0, 3, STS_OK,    4)},
            '{OP_LOOKUP, 7'd0,   32'h5555_5555, 0, '0}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i])
            send(plan[i].op, int'(plan[i].idx), plan[i].key, plan[i].typed, plan[i].want);

        sent  = 0;
        round = 0;
        while (sent < ITEMS) begin
            round++;
            // grow to full with mostly sorted inserts, then knock on a full table
            while (shadow_count < TABLE_DEPTH) begin
                k = pick_key();
                case ($urandom_range(9))
                    0: send(OP_INSERT, $urandom_range(127), k);
                    1: send(OP_FIND, $urandom_range(127), k);
                    2: send(OP_LOOKUP, $urandom_range(127), k);
                    default: begin
                        slot = 0;
                        for (int i = 0; i < shadow_count; i++)
                            if (shadow_keys[i] < k)
                                slot++;
                        send(OP_INSERT, slot, k);
                    end
                endcase
                sent++;
            end
            repeat (3) begin
                send(OP_INSERT, $urandom_range(127), pick_key());
                send(OP_LOOKUP, $urandom_range(127), pick_key());
                sent += 2;
            end
            // drain
            while (shadow_count > 0) begin
                case ($urandom_range(19))
                    0: send(OP_REMOVE, $urandom_range(127), pick_key());
                    1, 2: send(OP_FIND, $urandom_range(127), pick_key());
                    3, 4: send(OP_LOOKUP, $urandom_range(127), pick_key());
                    default: send(OP_REMOVE, $urandom_range(shadow_count - 1), pick_key());
                endcase
                sent++;
            end
            repeat (2) begin
                send(OP_REMOVE, $urandom_range(127), pick_key());
                send(OP_LOOKUP, $urandom_range(127), pick_key());
                sent += 2;
            end
            // mixed traffic; the second round runs it back to back
            steady = (round == 2);
            repeat (100) begin
                k = pick_key();
                case ($urandom_range(3))
                    0: send(OP_INSERT, $urandom_range(1) ? $urandom_range(127)
                                       : $urandom_range(shadow_count), k);
                    1: send(OP_REMOVE, $urandom_range(1) ? $urandom_range(127)
                                       : $urandom_range(shadow_count), k);
                    2: send(OP_FIND, $urandom_range(127), k);
                    default: send(OP_LOOKUP, $urandom_range(127), k);
                endcase
                sent++;
            end
            steady = 1'b0;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("indexed_table_insert_remove_search_top_tb OK");
        else
            $display("indexed_table_insert_remove_search_top_tb NOT OK");
        $finish;
    end

endmodule
